[hw/rtl/bam_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bam_pkg;

  localparam int VOL_W      = 12;
  localparam int PRES_W     = 10;
  localparam int RUN_W      = 4;
  localparam int BPM_W      = 6;
  localparam int MINUTE_W   = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [MINUTE_W-1:0] MINUTE_MAX = 17'd131071;

  localparam logic [CFG_IDX_W-1:0] REG_DISC_PRESSURE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISC_BREATHS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BPM           = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT    = 3'd4;

  localparam logic ACT_BREATH = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SUM,
    ST_CHECK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic wr_en;
    logic start;
  } win_cmd_t;

  typedef struct packed {
    logic done;
  } win_stat_t;

endpackage

`default_nettype wire

[hw/rtl/bam_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface bam_in_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [bam_pkg::VOL_W-1:0]    breath_volume;
  logic [bam_pkg::PRES_W-1:0]   peak_pressure;

  modport source (output valid, output action, output breath_volume,
                  output peak_pressure, input ready);
  modport sink (input valid, input action, input breath_volume,
                input peak_pressure, output ready);
endinterface

interface bam_out_if;
  logic                         valid;
  logic                         ready;
  logic                         disconnect_alarm;
  logic                         low_volume_alarm;
  logic                         high_volume_alarm;
  logic                         beeper_on;
  logic [bam_pkg::MINUTE_W-1:0] minute_volume;
  logic                         minute_valid;

  modport source (output valid, output disconnect_alarm, output low_volume_alarm,
                  output high_volume_alarm, output beeper_on, output minute_volume,
                  output minute_valid, input ready);
  modport sink (input valid, input disconnect_alarm, input low_volume_alarm,
                input high_volume_alarm, input beeper_on, input minute_volume,
                input minute_valid, output ready);
endinterface

`default_nettype wire

[hw/rtl/bam_window.sv]
`timescale 1ns / 1ps
`default_nettype none

module bam_window #(
  parameter int HISTORY_DEPTH = 32
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  bam_pkg::win_cmd_t                cmd,
  input  wire  [$clog2(HISTORY_DEPTH)-1:0]   head,
  input  wire  [$clog2(HISTORY_DEPTH+1)-1:0] count,
  input  wire  [bam_pkg::VOL_W-1:0]        wr_data,
  output bam_pkg::win_stat_t               stat,
  output logic [bam_pkg::MINUTE_W-1:0]     sum
);

  localparam int PW = $clog2(HISTORY_DEPTH);
  localparam int CW = $clog2(HISTORY_DEPTH+1);

  logic [bam_pkg::VOL_W-1:0] mem [HISTORY_DEPTH];

  logic [PW-1:0]               rd_addr_r, rd_addr_nxt;
  logic [CW-1:0]               left_r, left_nxt;
  logic                        rv_r, rv_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [bam_pkg::VOL_W-1:0]   rd_data_r;
  logic [bam_pkg::MINUTE_W-1:0] acc_r, acc_nxt;
  logic [bam_pkg::MINUTE_W:0]  acc_add;
  logic                        issue;

  assign issue   = (left_r != '0);
  assign acc_add = {1'b0, acc_r} + {{(bam_pkg::MINUTE_W+1-bam_pkg::VOL_W){1'b0}}, rd_data_r};

  always_comb begin
    rd_addr_nxt = rd_addr_r;
    left_nxt    = left_r;
    rv_nxt      = issue;
    busy_nxt    = busy_r;
    done_nxt    = 1'b0;
    acc_nxt     = acc_r;
    if (cmd.start) begin
      rd_addr_nxt = head;
      left_nxt    = count;
      rv_nxt      = 1'b0;
      busy_nxt    = 1'b1;
      acc_nxt     = '0;
    end else begin
      if (issue) begin
        rd_addr_nxt = (rd_addr_r == '0) ? PW'(HISTORY_DEPTH-1) : rd_addr_r - 1'b1;
        left_nxt    = left_r - 1'b1;
      end
      if (rv_r) begin
        acc_nxt = acc_add[bam_pkg::MINUTE_W] ? bam_pkg::MINUTE_MAX
                                             : acc_add[bam_pkg::MINUTE_W-1:0];
      end
      if (busy_r && !issue && (rv_r || left_r == '0) && !(rv_r && issue)) begin
        if (rv_r || !issue) begin
          done_nxt = 1'b1;
          busy_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[head] <= wr_data;
    end
    if (issue) begin
      rd_data_r <= mem[rd_addr_r];
    end
    acc_r     <= acc_nxt;
    rd_addr_r <= rd_addr_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
      rv_r   <= 1'b0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      left_r <= left_nxt;
      rv_r   <= rv_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign stat.done = done_r;
  assign sum       = acc_r;

endmodule

`default_nettype wire

[hw/rtl/breath_alarm_monitor_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  handshake          payload
// in_ch    in   valid/ready        action, breath_volume, peak_pressure
// out_ch   out  valid/ready        alarms, beeper_on, minute_volume, minute_valid
// cfg_*    in   cfg_we, no stall   cfg_index selects register, cfg_data
//
// A breath word passes ST_UPDATE, ST_SUM, ST_CHECK, ST_DONE when the window is summed
// (one history read per cycle through a single adder), ST_UPDATE, ST_CHECK, ST_DONE with
// an empty window; a clear word or a breath without enough history goes ST_UPDATE, ST_DONE.
// in_ch.ready is high only in idle, so the next word can be taken in the cycle after ST_DONE loads the result.
// Synchronous active-low reset clears state and loads register defaults.
// A result waits in the output register while out_ch stalls; the next word is
// accepted meanwhile and holds in its last step until the register frees.

module breath_alarm_monitor_core #(
  parameter int HISTORY_DEPTH = 32
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  bam_in_if.sink                              in_ch,
  bam_out_if.source                           out_ch,
  input  wire                                 cfg_we,
  input  wire  [bam_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [bam_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int PW = $clog2(HISTORY_DEPTH);
  localparam int CW = $clog2(HISTORY_DEPTH+1);
  localparam int WW = (CW > bam_pkg::BPM_W) ? CW : bam_pkg::BPM_W;

  bam_pkg::state_t state_r, state_nxt;

  logic [bam_pkg::PRES_W-1:0]   cfg_pres_r;
  logic [bam_pkg::RUN_W-1:0]    cfg_breaths_r;
  logic [bam_pkg::BPM_W-1:0]    cfg_bpm_r;
  logic [bam_pkg::MINUTE_W-1:0] cfg_low_r;
  logic [bam_pkg::MINUTE_W-1:0] cfg_high_r;

  logic                         action_r;
  logic [bam_pkg::VOL_W-1:0]    vol_r;
  logic [bam_pkg::PRES_W-1:0]   pip_r;

  logic [PW-1:0]                ptr_r, ptr_nxt;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic [bam_pkg::RUN_W-1:0]    run_r, run_nxt;
  logic                         disc_r, disc_nxt;
  logic                         low_r, low_nxt;
  logic                         high_r, high_nxt;
  logic                         beep_r, beep_nxt;
  logic [bam_pkg::MINUTE_W-1:0] minute_r, minute_nxt;
  logic                         mvalid_r, mvalid_nxt;

  logic                         ov_r, ov_nxt;
  logic                         o_disc_r, o_low_r, o_high_r, o_beep_r, o_mvalid_r;
  logic [bam_pkg::MINUTE_W-1:0] o_minute_r;
  logic                         o_load;

  logic [PW-1:0]                ptr_inc;
  logic [bam_pkg::RUN_W-1:0]    thr;
  logic                         win_ok;

  bam_pkg::win_cmd_t            wcmd;
  bam_pkg::win_stat_t           wstat;
  logic [bam_pkg::MINUTE_W-1:0] wsum;

  bam_window #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (wcmd),
    .head    (ptr_inc),
    .count   (CW'(cfg_bpm_r)),
    .wr_data (vol_r),
    .stat    (wstat),
    .sum     (wsum)
  );

  assign ptr_inc = (ptr_r == PW'(HISTORY_DEPTH-1)) ? '0 : ptr_r + 1'b1;
  assign thr     = (cfg_breaths_r == '0) ? bam_pkg::RUN_W'(1) : cfg_breaths_r;
  assign win_ok  = WW'(cnt_nxt) >= WW'(cfg_bpm_r);

  assign in_ch.ready = (state_r == bam_pkg::ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    ptr_nxt    = ptr_r;
    cnt_nxt    = cnt_r;
    run_nxt    = run_r;
    disc_nxt   = disc_r;
    low_nxt    = low_r;
    high_nxt   = high_r;
    beep_nxt   = beep_r;
    minute_nxt = minute_r;
    mvalid_nxt = mvalid_r;
    wcmd       = '0;
    o_load     = 1'b0;
    ov_nxt     = ov_r && !out_ch.ready;

    case (state_r)
      bam_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = bam_pkg::ST_UPDATE;
        end
      end
      bam_pkg::ST_UPDATE: begin
        minute_nxt = '0;
        mvalid_nxt = 1'b0;
        if (action_r == bam_pkg::ACT_CLEAR) begin
          disc_nxt  = 1'b0;
          low_nxt   = 1'b0;
          high_nxt  = 1'b0;
          beep_nxt  = 1'b0;
          state_nxt = bam_pkg::ST_DONE;
        end else begin
          ptr_nxt    = ptr_inc;
          wcmd.wr_en = 1'b1;
          if (cnt_r < CW'(HISTORY_DEPTH)) begin
            cnt_nxt = cnt_r + 1'b1;
          end
          if (pip_r < cfg_pres_r) begin
            if (run_r < thr) begin
              run_nxt = run_r + 1'b1;
            end
          end else begin
            run_nxt = '0;
          end
          if (run_nxt >= thr) begin
            disc_nxt = 1'b1;
            beep_nxt = 1'b1;
          end
          if (!win_ok) begin
            state_nxt = bam_pkg::ST_DONE;
          end else if (cfg_bpm_r == '0) begin
            state_nxt = bam_pkg::ST_CHECK;
          end else begin
            wcmd.start = 1'b1;
            state_nxt  = bam_pkg::ST_SUM;
          end
        end
      end
      bam_pkg::ST_SUM: begin
        if (wstat.done) begin
          minute_nxt = wsum;
          state_nxt  = bam_pkg::ST_CHECK;
        end
      end
      bam_pkg::ST_CHECK: begin
        mvalid_nxt = 1'b1;
        if (minute_r < cfg_low_r) begin
          low_nxt  = 1'b1;
          beep_nxt = 1'b1;
        end
        if (minute_r > cfg_high_r) begin
          high_nxt = 1'b1;
          beep_nxt = 1'b1;
        end
        state_nxt = bam_pkg::ST_DONE;
      end
      bam_pkg::ST_DONE: begin
        if (!ov_r || out_ch.ready) begin
          o_load    = 1'b1;
          ov_nxt    = 1'b1;
          state_nxt = bam_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bam_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= bam_pkg::ST_IDLE;
      ptr_r         <= '0;
      cnt_r         <= '0;
      run_r         <= '0;
      disc_r        <= 1'b0;
      low_r         <= 1'b0;
      high_r        <= 1'b0;
      beep_r        <= 1'b0;
      ov_r          <= 1'b0;
      cfg_pres_r    <= 10'd5;
      cfg_breaths_r <= 4'd3;
      cfg_bpm_r     <= 6'd15;
      cfg_low_r     <= 17'd0;
      cfg_high_r    <= 17'd131040;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      cnt_r   <= cnt_nxt;
      run_r   <= run_nxt;
      disc_r  <= disc_nxt;
      low_r   <= low_nxt;
      high_r  <= high_nxt;
      beep_r  <= beep_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) begin
        case (cfg_index)
          bam_pkg::REG_DISC_PRESSURE: cfg_pres_r    <= cfg_data[bam_pkg::PRES_W-1:0];
          bam_pkg::REG_DISC_BREATHS:  cfg_breaths_r <= cfg_data[bam_pkg::RUN_W-1:0];
          bam_pkg::REG_BPM:           cfg_bpm_r     <= cfg_data[bam_pkg::BPM_W-1:0];
          bam_pkg::REG_LOW_LIMIT:     cfg_low_r     <= cfg_data[bam_pkg::MINUTE_W-1:0];
          bam_pkg::REG_HIGH_LIMIT:    cfg_high_r    <= cfg_data[bam_pkg::MINUTE_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      action_r <= in_ch.action;
      vol_r    <= in_ch.breath_volume;
      pip_r    <= in_ch.peak_pressure;
    end
    minute_r <= minute_nxt;
    mvalid_r <= mvalid_nxt;
    if (o_load) begin
      o_disc_r   <= disc_r;
      o_low_r    <= low_r;
      o_high_r   <= high_r;
      o_beep_r   <= beep_r;
      o_minute_r <= minute_r;
      o_mvalid_r <= mvalid_r;
    end
  end

  assign out_ch.valid             = ov_r;
  assign out_ch.disconnect_alarm  = o_disc_r;
  assign out_ch.low_volume_alarm  = o_low_r;
  assign out_ch.high_volume_alarm = o_high_r;
  assign out_ch.beeper_on         = o_beep_r;
  assign out_ch.minute_volume     = o_minute_r;
  assign out_ch.minute_valid      = o_mvalid_r;

endmodule

`default_nettype wire

[dv/bam_checker.sv]
`timescale 1ns / 1ps

module bam_checker #(
  parameter int HISTORY_DEPTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  bam_in_if                                   in_mon,
  bam_out_if                                  out_mon,
  input  logic                                cfg_we,
  input  logic [bam_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bam_pkg::CFG_DATA_W-1:0]      cfg_data,
  output int                                  mismatches,
  output int                                  results_seen,
  output int                                  windowed_results,
  output int                                  alarm_results,
  output int                                  pending_words
);
  import bam_pkg::*;

  typedef struct packed {
    logic                disc;
    logic                low_vol;
    logic                high_vol;
    logic                beep;
    logic [MINUTE_W-1:0] minute;
    logic                mvalid;
  } alarm_word_t;

  // register mirror
  logic [PRES_W-1:0]   thr_pressure;
  logic [RUN_W-1:0]    thr_breaths;
  logic [BPM_W-1:0]    window_len;
  logic [MINUTE_W-1:0] min_limit;
  logic [MINUTE_W-1:0] max_limit;

  // breath history and alarm state
  logic [VOL_W-1:0]    vol_hist [HISTORY_DEPTH];
  int unsigned         newest;
  int unsigned         held;
  logic [RUN_W-1:0]    low_run;
  logic                alarm_disc;
  logic                alarm_low;
  logic                alarm_high;
  logic                beep;

  alarm_word_t         expected_words[$];
  int                  n_bad;
  int                  n_results;
  int                  n_windowed;
  int                  n_alarmed;

  function automatic alarm_word_t next_alarm_word(input logic act,
                                                  input logic [VOL_W-1:0] vol,
                                                  input logic [PRES_W-1:0] pres);
    alarm_word_t w;
    int unsigned thr;
    int unsigned pos;
    int unsigned acc;
    int unsigned i;
    w = '0;
    if (act == ACT_CLEAR) begin
      alarm_disc = 1'b0;
      alarm_low  = 1'b0;
      alarm_high = 1'b0;
      beep       = 1'b0;
    end else begin
      thr = (thr_breaths == '0) ? 1 : thr_breaths;
      newest = (newest + 1) % HISTORY_DEPTH;
      if (held < HISTORY_DEPTH) held++;
      vol_hist[newest] = vol;
      if (pres < thr_pressure) begin
        if (low_run < thr) low_run++;
      end else begin
        low_run = '0;
      end
      if (low_run >= thr) begin
        alarm_disc = 1'b1;
        beep       = 1'b1;
      end
      if (held >= window_len) begin
        acc = 0;
        pos = newest;
        for (i = 0; i < window_len; i++) begin
          acc += vol_hist[pos];
          pos = (pos == 0) ? HISTORY_DEPTH - 1 : pos - 1;
        end
        if (acc > MINUTE_MAX) acc = MINUTE_MAX;
        w.mvalid = 1'b1;
        w.minute = acc[MINUTE_W-1:0];
        if (w.minute < min_limit) begin
          alarm_low = 1'b1;
          beep      = 1'b1;
        end
        if (w.minute > max_limit) begin
          alarm_high = 1'b1;
          beep       = 1'b1;
        end
      end
    end
    w.disc     = alarm_disc;
    w.low_vol  = alarm_low;
    w.high_vol = alarm_high;
    w.beep     = beep;
    return w;
  endfunction

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("ERROR %0t: result %0d, %s: expected %0d, got %0d",
             $realtime, n_results, what, want, got);
    n_bad++;
  endtask

  initial begin
    n_bad      = 0;
    n_results  = 0;
    n_windowed = 0;
    n_alarmed  = 0;
  end

  always @(posedge clk) begin
    alarm_word_t want;
    if (!rst_n) begin
      thr_pressure = 10'd5;
      thr_breaths  = 4'd3;
      window_len   = 6'd15;
      min_limit    = 17'd0;
      max_limit    = 17'd131040;
      newest       = 0;
      held         = 0;
      low_run      = '0;
      alarm_disc   = 1'b0;
      alarm_low    = 1'b0;
      alarm_high   = 1'b0;
      beep         = 1'b0;
      expected_words.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DISC_PRESSURE: thr_pressure = cfg_data[PRES_W-1:0];
          REG_DISC_BREATHS:  thr_breaths  = cfg_data[RUN_W-1:0];
          REG_BPM:           window_len   = cfg_data[BPM_W-1:0];
          REG_LOW_LIMIT:     min_limit    = cfg_data[MINUTE_W-1:0];
          REG_HIGH_LIMIT:    max_limit    = cfg_data[MINUTE_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        expected_words.push_back(next_alarm_word(in_mon.action, in_mon.breath_volume,
                                                 in_mon.peak_pressure));
      if (out_mon.valid && out_mon.ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("result with nothing pending", 0, 1);
        end else begin
          want = expected_words.pop_front();
          if (out_mon.disconnect_alarm !== want.disc)
            report_mismatch("disconnect_alarm", want.disc, out_mon.disconnect_alarm);
          if (out_mon.low_volume_alarm !== want.low_vol)
            report_mismatch("low_volume_alarm", want.low_vol, out_mon.low_volume_alarm);
          if (out_mon.high_volume_alarm !== want.high_vol)
            report_mismatch("high_volume_alarm", want.high_vol, out_mon.high_volume_alarm);
          if (out_mon.beeper_on !== want.beep)
            report_mismatch("beeper_on", want.beep, out_mon.beeper_on);
          if (out_mon.minute_volume !== want.minute)
            report_mismatch("minute_volume", want.minute, out_mon.minute_volume);
          if (out_mon.minute_valid !== want.mvalid)
            report_mismatch("minute_valid", want.mvalid, out_mon.minute_valid);
          if (want.mvalid) n_windowed++;
          if (want.disc || want.low_vol || want.high_vol) n_alarmed++;
        end
        n_results++;
      end
    end
    mismatches       <= n_bad;
    results_seen     <= n_results;
    windowed_results <= n_windowed;
    alarm_results    <= n_alarmed;
    pending_words    <= expected_words.size();
  end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
  import bam_pkg::*;

  localparam int HIST_DEPTH  = 32;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_SUM     = 131040;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bam_in_if  in_ch ();
  bam_out_if out_ch ();

  int n_sent;
  int n_clears;
  int n_settings;
  int low_left;
  int cur_dp;
  int cur_db;
  bit quiet;
  bit hold_go;

  int mismatches;
  int results_seen;
  int windowed_results;
  int alarm_results;
  int pending_words;

  breath_alarm_monitor_core #(
    .HISTORY_DEPTH(HIST_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  bam_checker #(
    .HISTORY_DEPTH(HIST_DEPTH)
  ) i_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .results_seen    (results_seen),
    .windowed_results(windowed_results),
    .alarm_results   (alarm_results),
    .pending_words   (pending_words)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("Timeout: %0d words sent, %0d results seen", n_sent, results_seen);
    $display("Mismatches found");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side
  initial begin
    int stall;
    stall = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go <= 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        if (!quiet) stall = gap_len();
      end
    end
  end

  task automatic send_word(input logic act, input logic [VOL_W-1:0] vol,
                           input logic [PRES_W-1:0] pres);
    int gap;
    gap = quiet ? 0 : gap_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.action        <= act;
    in_ch.breath_volume <= vol;
    in_ch.peak_pressure <= pres;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_sent++;
    if (act == ACT_CLEAR) n_clears++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (results_seen != n_sent) @(posedge clk);
  endtask

  // junk in the bits above each register's width
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned v,
                           input int w);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'((longint'($urandom) << w) | v);
    @(posedge clk);
  endtask

  task automatic set_config(input int dp, input int db, input int bpm,
                            input int lo, input int hi);
    int j;
    drain();
    write_reg(REG_DISC_PRESSURE, dp, PRES_W);
    write_reg(REG_DISC_BREATHS, db, RUN_W);
    write_reg(REG_BPM, bpm, BPM_W);
    write_reg(REG_LOW_LIMIT, lo, MINUTE_W);
    write_reg(REG_HIGH_LIMIT, hi, MINUTE_W);
    for (j = REG_HIGH_LIMIT + 1; j < 2 ** CFG_IDX_W; j++)
      write_reg(CFG_IDX_W'(j), $urandom, CFG_DATA_W);
    cfg_we <= 1'b0;
    cur_dp = dp;
    cur_db = db;
    low_left = 0;
    n_settings++;
  endtask

  // breaths around a center volume, with runs of low-pressure breaths and some clears
  task automatic run_breaths(input int count, input int vc, input int spread);
    int k;
    int r;
    int v;
    logic act;
    logic [PRES_W-1:0] pres;
    for (k = 0; k < count; k++) begin
      act = ($urandom_range(0, 99) < 7) ? ACT_CLEAR : ACT_BREATH;
      r = $urandom_range(0, 99);
      if (r < 80) begin
        v = vc - spread + $urandom_range(0, 2 * spread);
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
      end else if (r < 86) begin
        v = 0;
      end else if (r < 92) begin
        v = 4095;
      end else begin
        v = $urandom_range(0, 4095);
      end
      if (low_left == 0 && $urandom_range(0, 7) == 0)
        low_left = $urandom_range(1, cur_db + 2);
      if (low_left > 0 && cur_dp > 0) begin
        pres = PRES_W'($urandom_range(0, cur_dp - 1));
        low_left--;
      end else if ($urandom_range(0, 9) == 0) begin
        pres = PRES_W'($urandom_range(0, 1023));
      end else begin
        pres = PRES_W'($urandom_range(cur_dp, 1023));
      end
      send_word(act, v[VOL_W-1:0], pres);
    end
  endtask

  initial begin
    int p;
    int bpm;
    int vc;
    int lo;
    int hi;
    n_sent = 0;
    n_clears = 0;
    n_settings = 0;
    low_left = 0;
    cur_dp = 5;
    cur_db = 3;
    quiet = 1'b0;
    hold_go = 1'b0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.action <= ACT_BREATH;
    in_ch.breath_volume <= '0;
    in_ch.peak_pressure <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // power-up register values: low-pressure run, saturation, clears, field extremes
    send_word(ACT_BREATH, 12'd4095, 10'd1023);
    send_word(ACT_BREATH, 12'd0, 10'd0);
    send_word(ACT_BREATH, 12'd1, 10'd4);
    send_word(ACT_BREATH, 12'd2, 10'd0);
    send_word(ACT_BREATH, 12'd3, 10'd0);
    send_word(ACT_CLEAR, 12'd4095, 10'd1023);
    send_word(ACT_BREATH, 12'd2048, 10'd0);
    send_word(ACT_BREATH, 12'd1024, 10'd5);
    send_word(ACT_CLEAR, 12'd0, 10'd0);
    for (p = 0; p < 10; p++)
      send_word(ACT_BREATH, p[0] ? 12'hAAA : 12'h555, p[0] ? 10'h2AA : 10'h155);
    send_word(ACT_BREATH, 12'd4095, 10'd512);
    send_word(ACT_CLEAR, 12'd7, 10'd3);
    send_word(ACT_BREATH, 12'd0, 10'd6);

    // no breath counts as low; zero run threshold; one-breath window; any nonzero volume is high
    set_config(0, 0, 1, 0, 0);
    run_breaths(40, 300, 300);

    // widest settings, full window, long output stall
    set_config(1023, 15, 32, MAX_SUM, MAX_SUM);
    run_breaths(5, 4000, 95);
    hold_go <= 1'b1;
    run_breaths(45, 4000, 95);

    // empty window: valid on every breath, sums to zero
    set_config(5, 1, 0, 1, 0);
    run_breaths(30, 500, 500);

    // window longer than the history never becomes valid
    set_config(20, 2, 63, 0, MAX_SUM);
    run_breaths(30, 800, 400);

    for (p = 0; p < 8; p++) begin
      bpm = $urandom_range(1, 32);
      vc = $urandom_range(100, 3000);
      lo = bpm * vc * $urandom_range(70, 95) / 100;
      hi = bpm * vc * $urandom_range(105, 130) / 100;
      if (lo > MAX_SUM) lo = MAX_SUM;
      if (hi > MAX_SUM) hi = MAX_SUM;
      set_config($urandom_range(3, 40), $urandom_range(1, 15), bpm, lo, hi);
      quiet <= (p == 2);
      run_breaths(50, vc, $urandom_range(0, vc / 4));
    end

    quiet <= 1'b0;
    drain();
    repeat (80) @(posedge clk);
    $display("Run covered %0d words (%0d clears) over %0d register settings plus reset values.",
             n_sent, n_clears, n_settings);
    $display("%0d results held a minute volume, %0d showed a raised alarm.",
             windowed_results, alarm_results);
    if (mismatches == 0 && pending_words == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
